### design/gshpd_pkg.sv
`default_nettype none

package gshpd_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Integral accumulator: width and clamp, in 1/16 degree times ticks.
    localparam int INT_W     = 17;
    localparam int INT_LIMIT = 40000;

    // Command thresholds.
    localparam logic [8:0] THROTTLE_MIN = 9'd15;
    localparam logic [8:0] STEER_MIN    = 9'd10;

    // Depth of the queue between the front and the back.
    localparam int Q_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLOVE_MODE      = 3'd0,
        CFG_TURN_PWM_AUTO   = 3'd1,
        CFG_TURN_PWM_GLOVE  = 3'd2,
        CFG_STEER_DEADZONE  = 3'd3,
        CFG_SETTLE_TICKS    = 3'd4,
        CFG_REVERSE_PWM     = 3'd5,
        CFG_INTEGRAL_WINDOW = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_STOP   = 3'd0,
        MODE_FWD    = 3'd1,
        MODE_REV    = 3'd2,
        MODE_SPIN_L = 3'd3,
        MODE_SPIN_R = 3'd4
    } t_mode;

    typedef struct packed {
        logic        glove_mode;
        logic [7:0]  turn_pwm_auto;
        logic [7:0]  turn_pwm_glove;
        logic [7:0]  steer_deadzone;
        logic [4:0]  settle_ticks;
        logic [7:0]  reverse_pwm;
        logic [11:0] integral_window;
    } t_cfg;

    // Gear parameters. kd5 is fifty times Kd; ki_on says whether Ki is nonzero.
    typedef struct packed {
        logic [7:0] base;
        logic [3:0] boost;
        logic [4:0] kp;
        logic [6:0] kd5;
        logic       ki_on;
    } t_gear;

    // Classified command as it travels from the front to the back.
    typedef struct packed {
        t_mode      mode;
        t_gear      gear;
        logic [7:0] fix_l;
        logic [7:0] fix_r;
    } t_cls;

    function automatic t_gear gear_of(input logic [7:0] speed);
        t_gear g;
        if (speed < 8'd140) begin
            g = '0;
        end else if (speed == 8'd140) begin
            g = '{base: 8'd165, boost: 4'd10, kp: 5'd5, kd5: 7'd50, ki_on: 1'b1};
        end else if (speed inside {[8'd141:8'd180]}) begin
            g = '{base: 8'd150, boost: 4'd15, kp: 5'd19, kd5: 7'd75, ki_on: 1'b1};
        end else if (speed inside {[8'd181:8'd200]}) begin
            g = '{base: 8'd180, boost: 4'd15, kp: 5'd16, kd5: 7'd85, ki_on: 1'b1};
        end else begin
            g = '{base: 8'd220, boost: 4'd15, kp: 5'd8, kd5: 7'd100, ki_on: 1'b1};
        end
        return g;
    endfunction

endpackage

`default_nettype wire

### design/gshpd_in_if.sv
`default_nettype none

interface gshpd_in_if #(
    parameter int HEADING_WIDTH = 16
);
    logic                            valid;
    logic                            ready;
    logic signed [HEADING_WIDTH-1:0] heading;
    logic signed [8:0]               throttle_cmd;
    logic signed [8:0]               steer_cmd;
    logic        [7:0]               speed_setting;

    modport source (
        output valid, heading, throttle_cmd, steer_cmd, speed_setting,
        input  ready
    );

    modport sink (
        input  valid, heading, throttle_cmd, steer_cmd, speed_setting,
        output ready
    );
endinterface

`default_nettype wire

### design/gshpd_out_if.sv
`default_nettype none

interface gshpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] left_pwm;
    logic [7:0] right_pwm;
    logic [2:0] drive_mode;

    modport source (
        output valid, left_pwm, right_pwm, drive_mode,
        input  ready
    );

    modport sink (
        input  valid, left_pwm, right_pwm, drive_mode,
        output ready
    );
endinterface

`default_nettype wire

### design/gain_scheduled_heading_pid_drive_core.sv
`default_nettype none

// Heading-hold drive for a two-wheel robot, one transfer per 20 ms control
// tick. Each input transfer carries the measured heading (1/16 degree), the
// throttle and steer commands and a speed setting; each one yields exactly one
// output transfer with the left and right PWM duty and the drive mode. The
// speed setting selects a gear (base PWM, PID gains, left-wheel boost); a PID
// on held target heading minus heading trims the wheels when driving forward,
// reverse and spin turns use fixed PWM values, and small commands stop the
// robot. The block takes one transfer per clock cycle while the output side is
// not stalled, a rate set by the loop state (target heading, integral, last
// error, settle counter), which the execution stage updates once per tick.
// When the output side is free, an accepted command waits in the queue and then
// in the output register. A two-entry queue separates command classification
// from execution, so input ready only drops once the output has been held off
// with one tick in the output register and two more queued. The user must write
// configuration registers through the plain write port only while the block is
// idle; the block does not enforce this. Writes to an unused index are ignored.

module gain_scheduled_heading_pid_drive_core import gshpd_pkg::*; #(
    parameter int HEADING_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    gshpd_in_if.sink              i_in,
    gshpd_out_if.source           o_out
);

    localparam int CLS_W = $bits(t_cls);
    localparam int QW    = HEADING_WIDTH + CLS_W;

    // Configuration registers, reset to their documented defaults.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glove_mode      <= 1'b0;
            r_cfg.turn_pwm_auto   <= 8'd215;
            r_cfg.turn_pwm_glove  <= 8'd200;
            r_cfg.steer_deadzone  <= 8'd70;
            r_cfg.settle_ticks    <= 5'd15;
            r_cfg.reverse_pwm     <= 8'd180;
            r_cfg.integral_window <= 12'd160;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GLOVE_MODE:      r_cfg.glove_mode      <= i_cfg_data[0];
                CFG_TURN_PWM_AUTO:   r_cfg.turn_pwm_auto   <= i_cfg_data[7:0];
                CFG_TURN_PWM_GLOVE:  r_cfg.turn_pwm_glove  <= i_cfg_data[7:0];
                CFG_STEER_DEADZONE:  r_cfg.steer_deadzone  <= i_cfg_data[7:0];
                CFG_SETTLE_TICKS:    r_cfg.settle_ticks    <= i_cfg_data[4:0];
                CFG_REVERSE_PWM:     r_cfg.reverse_pwm     <= i_cfg_data[7:0];
                CFG_INTEGRAL_WINDOW: r_cfg.integral_window <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // The front classifies each command as it is accepted: gear lookup,
    // glove dead zone, drive mode and the fixed PWM values of spin and reverse.
    t_cls w_cls;

    gshpd_front u_front (
        .i_cfg      (r_cfg),
        .i_throttle (i_in.throttle_cmd),
        .i_steer    (i_in.steer_cmd),
        .i_speed    (i_in.speed_setting),
        .o_cls      (w_cls)
    );

    // Queue between classification and execution.
    logic          w_q_full;
    logic          w_q_valid;
    logic          w_q_pop;
    logic          w_push;
    logic [QW-1:0] w_q_data;
    t_cls          w_q_cls;
    logic signed [HEADING_WIDTH-1:0] w_q_heading;

    assign i_in.ready = !w_q_full;
    assign w_push     = i_in.valid && !w_q_full;

    gshpd_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({i_in.heading, w_cls}),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    assign w_q_heading = $signed(w_q_data[QW-1:CLS_W]);
    assign w_q_cls     = t_cls'(w_q_data[CLS_W-1:0]);

    // The back runs the PID and the loop state and holds the output register.
    gshpd_back #(
        .HEADING_WIDTH (HEADING_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_heading (w_q_heading),
        .i_q_cls     (w_q_cls),
        .o_q_pop     (w_q_pop),
        .o_out       (o_out)
    );

    // Input ready only drops when the previous cycle had a stalled output.
    a_ready_drop_needs_stall: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> $past(o_out.valid && !o_out.ready)
    ) else $error("input ready dropped without an output stall");

    // An accepted command is either queued or in the output register.
    a_accept_is_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (w_q_valid || o_out.valid)
    ) else $error("accepted command lost");

    // A stop result drives both wheels at zero.
    a_stop_is_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.drive_mode == MODE_STOP)
            |-> (o_out.left_pwm == 8'd0 && o_out.right_pwm == 8'd0)
    ) else $error("stop result with nonzero PWM");

endmodule

`default_nettype wire

### design/gshpd_front.sv
`default_nettype none

module gshpd_front import gshpd_pkg::*; (
    input  t_cfg              i_cfg,
    input  logic signed [8:0] i_throttle,
    input  logic signed [8:0] i_steer,
    input  logic [7:0]        i_speed,
    output t_cls              o_cls
);

    logic [8:0] w_thr_mag;
    logic [8:0] w_str_mag;
    logic       w_steer_dead;
    logic       w_spin;
    logic       w_fwd;
    logic       w_rev;
    logic [7:0] w_turn_pwm;
    logic [8:0] w_rev_left;
    t_gear      w_gear;

    always_comb begin
        w_thr_mag    = i_throttle[8] ? $unsigned(-i_throttle) : $unsigned(i_throttle);
        w_str_mag    = i_steer[8] ? $unsigned(-i_steer) : $unsigned(i_steer);
        w_gear       = gear_of(i_speed);

        // In glove mode small steer deflections are ignored.
        w_steer_dead = i_cfg.glove_mode && (w_str_mag <= {1'b0, i_cfg.steer_deadzone});
        w_spin       = !w_steer_dead && (w_str_mag > STEER_MIN);
        w_fwd        = !i_throttle[8] && (w_thr_mag > THROTTLE_MIN);
        w_rev        = i_throttle[8] && (w_thr_mag > THROTTLE_MIN);

        w_turn_pwm   = i_cfg.glove_mode ? i_cfg.turn_pwm_glove : i_cfg.turn_pwm_auto;
        w_rev_left   = {1'b0, i_cfg.reverse_pwm} + {5'd0, w_gear.boost};

        o_cls.gear   = w_gear;
        if (w_spin) begin
            o_cls.mode  = i_steer[8] ? MODE_SPIN_R : MODE_SPIN_L;
            o_cls.fix_l = w_turn_pwm;
            o_cls.fix_r = w_turn_pwm;
        end else if (w_fwd) begin
            o_cls.mode  = MODE_FWD;
            o_cls.fix_l = '0;
            o_cls.fix_r = '0;
        end else if (w_rev) begin
            o_cls.mode  = MODE_REV;
            o_cls.fix_l = w_rev_left[8] ? 8'hFF : w_rev_left[7:0];
            o_cls.fix_r = i_cfg.reverse_pwm;
        end else begin
            o_cls.mode  = MODE_STOP;
            o_cls.fix_l = '0;
            o_cls.fix_r = '0;
        end
    end

endmodule

`default_nettype wire

### design/gshpd_queue.sv
`default_nettype none

module gshpd_queue import gshpd_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [Q_DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_wr;
    logic [PW-1:0]    n_rd;
    logic [CW-1:0]    n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_full  = (r_count == CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

endmodule

`default_nettype wire

### design/gshpd_back.sv
`default_nettype none

module gshpd_back import gshpd_pkg::*; #(
    parameter int HEADING_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_cfg                            i_cfg,
    input  logic                            i_q_valid,
    input  logic signed [HEADING_WIDTH-1:0] i_q_heading,
    input  t_cls                            i_q_cls,
    output logic                            o_q_pop,
    gshpd_out_if.source                     o_out
);

    localparam int EW = HEADING_WIDTH + 1;
    localparam int DW = HEADING_WIDTH + 2;
    localparam int SW = ((EW > INT_W) ? EW : INT_W) + 1;
    localparam int AW = DW + 9;

    logic signed [HEADING_WIDTH-1:0] r_target;
    logic signed [INT_W-1:0]         r_integ;
    logic signed [EW-1:0]            r_last;
    logic                            r_wns;
    logic [4:0]                      r_cnt;
    logic                            r_out_valid;
    logic [7:0]                      r_left;
    logic [7:0]                      r_right;
    logic [2:0]                      r_mode;

    logic signed [HEADING_WIDTH-1:0] n_target;
    logic signed [INT_W-1:0]         n_integ;
    logic signed [EW-1:0]            n_last;
    logic                            n_wns;
    logic [4:0]                      n_cnt;
    logic [7:0]                      n_left;
    logic [7:0]                      n_right;

    logic signed [EW-1:0]   w_err;
    logic [EW-1:0]          w_err_mag;
    logic                   w_in_win;
    logic signed [SW-1:0]   w_sum;
    logic signed [SW-1:0]   w_s1;
    logic signed [INT_W-1:0] w_s2;
    logic signed [DW-1:0]   w_diff;
    logic signed [EW+5:0]   w_prod_p;
    logic signed [DW+7:0]   w_prod_d;
    logic signed [AW-1:0]   w_acc;
    logic signed [AW-1:0]   w_acc_neg;
    logic signed [AW-1:0]   w_shr_r;
    logic signed [AW-1:0]   w_shr_l;
    logic signed [AW-1:0]   w_corr_r;
    logic signed [AW-1:0]   w_corr_l;
    logic signed [AW-1:0]   w_val_r;
    logic signed [AW-1:0]   w_val_l;
    logic                   w_frac0;
    logic                   w_adj_r;
    logic                   w_adj_l;
    logic [4:0]             w_cnt_eff;
    logic                   w_straight;
    logic                   w_settle;
    logic                   w_use_corr;

    function automatic logic [7:0] pwm_clamp(input logic signed [AW-1:0] v);
        logic [7:0] p;
        if (v[AW-1]) begin
            p = '0;
        end else if (|v[AW-2:8]) begin
            p = 8'hFF;
        end else begin
            p = v[7:0];
        end
        return p;
    endfunction

    assign o_q_pop = i_q_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        // Heading error and integral update.
        w_err     = EW'(r_target) - EW'(i_q_heading);
        w_err_mag = w_err[EW-1] ? $unsigned(-w_err) : $unsigned(w_err);
        w_in_win  = w_err_mag < EW'(i_cfg.integral_window);
        w_sum     = SW'(r_integ) + SW'(w_err);
        w_s1      = w_in_win ? w_sum : '0;
        if (w_s1 > SW'(INT_LIMIT)) begin
            w_s2 = INT_W'(INT_LIMIT);
        end else if (w_s1 < SW'(-INT_LIMIT)) begin
            w_s2 = INT_W'(-INT_LIMIT);
        end else begin
            w_s2 = INT_W'(w_s1);
        end

        // Proportional and derivative part, in units of 1/16 PWM step.
        w_diff    = DW'(w_err) - DW'(r_last);
        w_prod_p  = $signed({1'b0, i_q_cls.gear.kp}) * w_err;
        w_prod_d  = $signed({1'b0, i_q_cls.gear.kd5}) * w_diff;
        w_acc     = AW'(w_prod_p) + AW'(w_prod_d);
        w_acc_neg = -w_acc;

        // The integral term stays below one sixteenth of a PWM step, so it
        // only moves the floor when the P and D part is a whole step.
        w_frac0   = (w_acc[3:0] == 4'd0);
        w_adj_r   = w_frac0 && i_q_cls.gear.ki_on && w_s2[INT_W-1];
        w_adj_l   = w_frac0 && i_q_cls.gear.ki_on && !w_s2[INT_W-1] && (w_s2 != '0);
        w_shr_r   = w_acc >>> 4;
        w_shr_l   = w_acc_neg >>> 4;
        w_corr_r  = w_shr_r - $signed(AW'(w_adj_r));
        w_corr_l  = w_shr_l - $signed(AW'(w_adj_l));

        // Settle window after a spin or a stop.
        w_straight = (i_q_cls.mode == MODE_FWD) || (i_q_cls.mode == MODE_REV);
        w_cnt_eff  = r_wns ? '0 : r_cnt;
        w_settle   = w_straight && (w_cnt_eff < i_cfg.settle_ticks);
        w_use_corr = (i_q_cls.mode == MODE_FWD) && !w_settle;

        w_val_r = $signed(AW'(i_q_cls.gear.base)) + (w_use_corr ? w_corr_r : '0);
        w_val_l = $signed(AW'(i_q_cls.gear.base)) + $signed(AW'(i_q_cls.gear.boost))
                + (w_use_corr ? w_corr_l : '0);

        if (i_q_cls.mode == MODE_FWD) begin
            n_left  = pwm_clamp(w_val_l);
            n_right = pwm_clamp(w_val_r);
        end else begin
            n_left  = i_q_cls.fix_l;
            n_right = i_q_cls.fix_r;
        end

        // Next loop state.
        n_target = i_q_heading;
        n_integ  = '0;
        n_last   = '0;
        n_wns    = 1'b1;
        n_cnt    = r_cnt;
        if (w_straight) begin
            n_wns = 1'b0;
            if (w_settle) begin
                n_cnt = w_cnt_eff + 1'b1;
            end else begin
                n_cnt    = w_cnt_eff;
                n_target = r_target;
                n_integ  = w_s2;
                n_last   = w_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_integ     <= '0;
            r_last      <= '0;
            r_wns       <= 1'b1;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_target    <= n_target;
                r_integ     <= n_integ;
                r_last      <= n_last;
                r_wns       <= n_wns;
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_mode  <= i_q_cls.mode;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.left_pwm   = r_left;
    assign o_out.right_pwm  = r_right;
    assign o_out.drive_mode = r_mode;

endmodule

`default_nettype wire

### dv/gain_scheduled_heading_pid_drive_core_test.sv
`timescale 1ns / 100ps

// Testbench for the gain-scheduled heading-hold drive core.
//
// Every input transfer is one control tick and yields exactly one output
// transfer. An in-bench copy of the drive behavior runs on every accepted
// tick and queues the wheel command it expects; each output transfer is
// checked field by field against the oldest queued command.
//
// The run opens with a short table of hand-picked ticks (stop, both spins,
// the steer and throttle thresholds, every gear, extreme headings, reverse
// saturation, the glove dead zone). Rows whose result is obvious carry it
// typed in; the rest go through the in-bench copy. Random phases follow, each
// under a fresh register setting and one of four idling profiles in turn.
module gain_scheduled_heading_pid_drive_core_test;
    import gshpd_pkg::*;

    localparam int     ITEMS_PER_PHASE = 120;
    localparam int     NUM_PHASES      = 8;
    localparam int     QUIET_LIMIT     = 3000;
    localparam int     HOLD_CYCLES     = 300;
    localparam int     TAIL_CYCLES     = 10;
    localparam longint DUTY_DEN        = 8000000;

    typedef struct {
        logic signed [15:0] heading;
        logic signed [8:0]  throttle;
        logic signed [8:0]  steer;
        logic        [7:0]  speed;
    } t_drive_tick;

    typedef struct {
        logic [7:0] left;
        logic [7:0] right;
        t_mode      mode;
    } t_wheel_cmd;

    // A table row is either a tick or a single register write.
    typedef struct {
        bit          is_cfg;
        t_cfg_idx    idx;
        logic [11:0] val;
        t_drive_tick tick;
        bit          fixed;
        t_wheel_cmd  want;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    gshpd_in_if #(.HEADING_WIDTH(16)) in_if ();
    gshpd_out_if                      out_if ();

    gain_scheduled_heading_pid_drive_core #(
        .HEADING_WIDTH(16)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Registers as the block should hold them, starting from their reset values.
    t_cfg drive_cfg = '{
        glove_mode: 1'b0, turn_pwm_auto: 8'd215, turn_pwm_glove: 8'd200,
        steer_deadzone: 8'd70, settle_ticks: 5'd15, reverse_pwm: 8'd180,
        integral_window: 12'd160
    };

    // Loop state of the drive, mirrored tick by tick.
    longint hold_target        = 0;
    longint integ_acc          = 0;
    longint prev_err           = 0;
    bit     turning_or_stopped = 1'b1;
    int     settle_cnt         = 0;

    t_wheel_cmd wheel_q[$];

    int idle_pct       = 0;
    int stall_pct      = 0;
    int hold_len       = 0;
    int ticks_sent     = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int settings_used  = 1;
    int quiet_cycles   = 0;
    logic signed [15:0] walk_heading = '0;

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Forward duty: floor of the exact value, clamped to 0..255.
    function automatic logic [7:0] duty_of(input longint num);
        longint q;
        if (num < 0) begin
            return 8'd0;
        end
        q = num / DUTY_DEN;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Advances the mirrored loop state by one tick and returns the wheel command.
    // The correction is kept as an integer over DUTY_DEN so that no rounding
    // step is ever needed.
    function automatic t_wheel_cmd predict_wheels(input t_drive_tick t);
        longint     hd, thr, str, err, corr, steer_eff, rev_l;
        longint     base, kp, ki, kd, boost;
        t_wheel_cmd w;
        hd    = t.heading;
        thr   = t.throttle;
        str   = t.steer;
        base  = 0;
        kp    = 0;
        ki    = 0;
        kd    = 0;
        boost = 0;
        w     = '{8'd0, 8'd0, MODE_STOP};

        // The error is formed one bit wider than the heading, so it never wraps.
        err = hold_target - hd;
        if (mag(err) < longint'(drive_cfg.integral_window)) begin
            integ_acc = integ_acc + err;
        end else begin
            integ_acc = 0;
        end
        if (mag(thr) <= 15 && mag(str) <= 10) begin
            integ_acc = 0;
            prev_err  = 0;
        end
        if (integ_acc > INT_LIMIT) begin
            integ_acc = INT_LIMIT;
        end
        if (integ_acc < -INT_LIMIT) begin
            integ_acc = -INT_LIMIT;
        end

        // Gear table; Ki is scaled by 10000 and Kd by 10.
        if (t.speed < 8'd140) begin
            base = 0;
        end else if (t.speed == 8'd140) begin
            base = 165; kp = 5; ki = 9; kd = 10; boost = 10;
        end else if (t.speed <= 8'd180) begin
            base = 150; kp = 19; ki = 9; kd = 15; boost = 15;
        end else if (t.speed <= 8'd200) begin
            base = 180; kp = 16; ki = 10; kd = 17; boost = 15;
        end else begin
            base = 220; kp = 8; ki = 9; kd = 20; boost = 15;
        end

        corr     = kp * err * 500000 + ki * integ_acc + kd * (err - prev_err) * 2500000;
        prev_err = err;

        // In glove mode small steer values fall into the dead zone.
        steer_eff = str;
        if (drive_cfg.glove_mode && mag(steer_eff) <= longint'(drive_cfg.steer_deadzone)) begin
            steer_eff = 0;
        end

        if (mag(steer_eff) > 10) begin
            turning_or_stopped = 1'b1;
            w.left  = drive_cfg.glove_mode ? drive_cfg.turn_pwm_glove : drive_cfg.turn_pwm_auto;
            w.right = w.left;
            w.mode  = (steer_eff > 10) ? MODE_SPIN_L : MODE_SPIN_R;
            integ_acc   = 0;
            prev_err    = 0;
            hold_target = hd;
        end else if (mag(thr) > 15) begin
            if (turning_or_stopped) begin
                settle_cnt         = 0;
                turning_or_stopped = 1'b0;
            end
            // While settling the target follows the heading and nothing is trimmed.
            if (settle_cnt < int'(drive_cfg.settle_ticks)) begin
                hold_target = hd;
                integ_acc   = 0;
                prev_err    = 0;
                corr        = 0;
                settle_cnt++;
            end
            if (thr > 15) begin
                w.left  = duty_of((base + boost) * DUTY_DEN - corr);
                w.right = duty_of(base * DUTY_DEN + corr);
                w.mode  = MODE_FWD;
            end else begin
                rev_l   = longint'(drive_cfg.reverse_pwm) + boost;
                w.left  = (rev_l > 255) ? 8'd255 : rev_l[7:0];
                w.right = drive_cfg.reverse_pwm;
                w.mode  = MODE_REV;
            end
        end else begin
            turning_or_stopped = 1'b1;
            integ_acc   = 0;
            prev_err    = 0;
            hold_target = hd;
        end
        return w;
    endfunction

    function automatic t_drive_tick make_tick(input int h, input int t, input int s,
                                              input int sp);
        t_drive_tick d;
        d.heading  = h[15:0];
        d.throttle = t[8:0];
        d.steer    = s[8:0];
        d.speed    = sp[7:0];
        return d;
    endfunction

    function automatic t_plan_row known_row(input int h, input int t, input int s,
                                            input int sp, input int l, input int r,
                                            input t_mode m);
        t_plan_row row;
        row.is_cfg = 1'b0;
        row.idx    = CFG_GLOVE_MODE;
        row.val    = '0;
        row.tick   = make_tick(h, t, s, sp);
        row.fixed  = 1'b1;
        row.want   = '{l[7:0], r[7:0], m};
        return row;
    endfunction

    function automatic t_plan_row model_row(input int h, input int t, input int s,
                                            input int sp);
        t_plan_row row;
        row       = known_row(h, t, s, sp, 0, 0, MODE_STOP);
        row.fixed = 1'b0;
        return row;
    endfunction

    function automatic t_plan_row cfg_row(input t_cfg_idx idx, input int val);
        t_plan_row row;
        row        = known_row(0, 0, 0, 0, 0, 0, MODE_STOP);
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.val    = val[11:0];
        return row;
    endfunction

    // Speeds that sit on the gear boundaries, plus a random one now and then.
    function automatic logic [7:0] pick_speed();
        int edges[9] = '{0, 139, 140, 141, 180, 181, 200, 201, 255};
        if ($urandom_range(0, 3) == 0) begin
            return 8'($urandom);
        end
        return 8'(edges[$urandom_range(0, 8)]);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] result %0d: %s got %0d, expected %0d",
                 $realtime, results_seen, what, got, want);
    endtask

    // All tasks below are entered at a falling edge and return at one, which
    // keeps every signal to a single nonblocking assignment per time step.

    // Offers one tick after a random number of idle cycles and holds it until the
    // block takes the transfer. The expectation is queued at acceptance.
    task automatic offer_tick(input t_drive_tick t, input bit fixed,
                              input t_wheel_cmd fixed_want);
        t_wheel_cmd w;
        while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.heading       <= t.heading;
        in_if.throttle_cmd  <= t.throttle;
        in_if.steer_cmd     <= t.steer;
        in_if.speed_setting <= t.speed;
        do @(posedge i_clk); while (!in_if.ready);
        w = predict_wheels(t);
        wheel_q.push_back(fixed ? fixed_want : w);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every queued result has come out.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        do @(negedge i_clk); while (wheel_q.size() != 0);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [11:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_GLOVE_MODE:      drive_cfg.glove_mode      = val[0];
            CFG_TURN_PWM_AUTO:   drive_cfg.turn_pwm_auto   = val[7:0];
            CFG_TURN_PWM_GLOVE:  drive_cfg.turn_pwm_glove  = val[7:0];
            CFG_STEER_DEADZONE:  drive_cfg.steer_deadzone  = val[7:0];
            CFG_SETTLE_TICKS:    drive_cfg.settle_ticks    = val[4:0];
            CFG_REVERSE_PWM:     drive_cfg.reverse_pwm     = val[7:0];
            CFG_INTEGRAL_WINDOW: drive_cfg.integral_window = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // The output side stalls at random as the phase asks. A long hold-off is
    // counted down here, independently of the sender, so that the block fills
    // up and has to drop its input ready.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                out_if.ready <= 1'b0;
                hold_len     <= hold_len - 1;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Checks each output transfer against the oldest expectation, and ends the
    // run if neither side moves a transfer for too long.
    always @(posedge i_clk) begin : result_check
        t_wheel_cmd want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (wheel_q.size() == 0) begin
                report_mismatch("result with no tick pending, mode", out_if.drive_mode, 0);
            end else begin
                want = wheel_q.pop_front();
                if (out_if.left_pwm !== want.left) begin
                    report_mismatch("left_pwm", out_if.left_pwm, want.left);
                end
                if (out_if.right_pwm !== want.right) begin
                    report_mismatch("right_pwm", out_if.right_pwm, want.right);
                end
                if (out_if.drive_mode !== want.mode) begin
                    report_mismatch("drive_mode", out_if.drive_mode, want.mode);
                end
            end
            results_seen++;
        end
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results still pending",
                     QUIET_LIMIT, wheel_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        t_plan_row   plan[$];
        t_cfg        c;
        t_drive_tick t;
        t_wheel_cmd  no_want;
        int          phase_start, run_len, gap_bias, kind, random_start;
        bit          forward, hold_done, pause_done;
        logic [7:0]  run_speed;

        no_want    = '{8'd0, 8'd0, MODE_STOP};
        hold_done  = 1'b0;
        pause_done = 1'b0;

        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = '0;
        cfg_data            = '0;
        in_if.valid         = 1'b0;
        in_if.heading       = '0;
        in_if.throttle_cmd  = '0;
        in_if.steer_cmd     = '0;
        in_if.speed_setting = '0;

        // Directed table, run under the reset register values unless a row
        // writes one. The default settle window is long enough that the straight
        // rows ahead of the settle-window write see a zero correction.
        plan.push_back(known_row(0, 0, 0, 0, 0, 0, MODE_STOP));
        plan.push_back(known_row(100, 0, 255, 0, 215, 215, MODE_SPIN_L));
        plan.push_back(known_row(-100, 0, -255, 0, 215, 215, MODE_SPIN_R));
        plan.push_back(known_row(0, 0, 10, 0, 0, 0, MODE_STOP));
        plan.push_back(known_row(0, 0, 11, 0, 215, 215, MODE_SPIN_L));
        plan.push_back(known_row(0, 0, -10, 0, 0, 0, MODE_STOP));
        plan.push_back(known_row(0, 0, -11, 0, 215, 215, MODE_SPIN_R));
        plan.push_back(known_row(0, 15, 0, 255, 0, 0, MODE_STOP));
        plan.push_back(known_row(0, 16, 0, 255, 235, 220, MODE_FWD));
        plan.push_back(known_row(500, -16, 0, 255, 195, 180, MODE_REV));
        plan.push_back(known_row(-32768, 255, 0, 140, 175, 165, MODE_FWD));
        plan.push_back(known_row(32767, -255, 0, 0, 180, 180, MODE_REV));
        plan.push_back(known_row(0, 255, 0, 139, 0, 0, MODE_FWD));
        plan.push_back(known_row(0, 255, 0, 180, 165, 150, MODE_FWD));
        plan.push_back(known_row(0, 255, 0, 200, 195, 180, MODE_FWD));
        plan.push_back(known_row(0, 255, 0, 201, 235, 220, MODE_FWD));
        // Without a settle window the PID acts at once; the heading swings from
        // one extreme to the other so the error reaches its full width.
        plan.push_back(cfg_row(CFG_SETTLE_TICKS, 0));
        plan.push_back(known_row(32767, 0, 0, 0, 0, 0, MODE_STOP));
        plan.push_back(model_row(-32768, 255, 0, 255));
        plan.push_back(model_row(32767, 255, 0, 181));
        plan.push_back(model_row(32700, 100, 5, 141));
        plan.push_back(model_row(32650, 100, -5, 141));
        // Reverse with the boost on top of a high reverse duty saturates.
        plan.push_back(cfg_row(CFG_REVERSE_PWM, 250));
        plan.push_back(known_row(0, -255, 0, 255, 255, 250, MODE_REV));
        // Glove mode: the dead zone swallows small steer, larger steer spins.
        plan.push_back(cfg_row(CFG_GLOVE_MODE, 1));
        plan.push_back(known_row(0, 0, 70, 0, 0, 0, MODE_STOP));
        plan.push_back(known_row(0, 0, -71, 0, 200, 200, MODE_SPIN_R));
        plan.push_back(known_row(0, 255, 255, 255, 200, 200, MODE_SPIN_L));

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                drain_results();
                write_reg(plan[i].idx, plan[i].val);
                settings_used++;
            end else begin
                offer_tick(plan[i].tick, plan[i].fixed, plan[i].want);
            end
        end
        random_start = ticks_sent;

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();

            // The first three phases use fixed settings: everything at its
            // lowest, everything at its highest, and the reset values.
            case (phase)
                0: c = '0;
                1: c = '1;
                2: c = '{1'b0, 8'd215, 8'd200, 8'd70, 5'd15, 8'd180, 12'd160};
                default: begin
                    c.glove_mode      = 1'($urandom_range(0, 1));
                    c.turn_pwm_auto   = 8'($urandom);
                    c.turn_pwm_glove  = 8'($urandom);
                    c.steer_deadzone  = ($urandom_range(0, 1) != 0) ?
                                        8'($urandom_range(0, 40)) : 8'($urandom);
                    c.settle_ticks    = ($urandom_range(0, 1) != 0) ?
                                        5'($urandom_range(0, 4)) : 5'($urandom);
                    c.reverse_pwm     = 8'($urandom);
                    c.integral_window = 12'($urandom);
                end
            endcase
            write_reg(CFG_GLOVE_MODE, {11'd0, c.glove_mode});
            write_reg(CFG_TURN_PWM_AUTO, {4'd0, c.turn_pwm_auto});
            write_reg(CFG_TURN_PWM_GLOVE, {4'd0, c.turn_pwm_glove});
            write_reg(CFG_STEER_DEADZONE, {4'd0, c.steer_deadzone});
            write_reg(CFG_SETTLE_TICKS, {7'd0, c.settle_ticks});
            write_reg(CFG_REVERSE_PWM, {4'd0, c.reverse_pwm});
            write_reg(CFG_INTEGRAL_WINDOW, c.integral_window);
            settings_used++;

            // Idling profiles rotate: none, sender mostly idle, receiver mostly
            // stalled, both idling now and then.
            case (phase % 4)
                0: begin idle_pct <= 0;  stall_pct <= 0;  end
                1: begin idle_pct <= 88; stall_pct <= 0;  end
                2: begin idle_pct <= 0;  stall_pct <= 88; end
                default: begin idle_pct <= 36; stall_pct <= 36; end
            endcase
            @(negedge i_clk);

            phase_start = ticks_sent;
            while (ticks_sent - phase_start < ITEMS_PER_PHASE) begin
                // Hold the output off for a long stretch while ticks keep coming.
                if (phase == 0 && !hold_done && ticks_sent - phase_start >= 20) begin
                    hold_len  <= HOLD_CYCLES;
                    hold_done  = 1'b1;
                end
                // Once, pause the sender until everything has come out.
                if (phase == 1 && !pause_done && ticks_sent - phase_start >= 60) begin
                    drain_results();
                    pause_done = 1'b1;
                end

                kind = $urandom_range(0, 99);
                if (kind < 65) begin
                    // A straight run: optionally start from a stop so the target
                    // locks, then let the heading drift with a bias so that the
                    // error, the integral and its clamp all get exercised.
                    if ($urandom_range(0, 1) != 0) begin
                        t = make_tick(walk_heading, $urandom_range(0, 30) - 15,
                                      $urandom_range(0, 20) - 10, pick_speed());
                        offer_tick(t, 1'b0, no_want);
                    end
                    run_len   = $urandom_range(3, 60);
                    forward   = ($urandom_range(0, 3) != 0);
                    run_speed = pick_speed();
                    gap_bias  = $urandom_range(0, 40) - 20;
                    for (int k = 0; k < run_len; k++) begin
                        walk_heading = walk_heading + 16'(gap_bias)
                                       + 16'($urandom_range(0, 16)) - 16'd8;
                        if ($urandom_range(0, 19) == 0) begin
                            walk_heading = walk_heading + 16'($urandom_range(0, 4000))
                                           - 16'd2000;
                        end
                        if ($urandom_range(0, 9) == 0) begin
                            run_speed = pick_speed();
                        end
                        t = make_tick(walk_heading,
                                      forward ? $urandom_range(16, 255)
                                              : -$urandom_range(16, 255),
                                      $urandom_range(0, 20) - 10, run_speed);
                        offer_tick(t, 1'b0, no_want);
                    end
                end else if (kind < 80) begin
                    // A short spin run; each spin tick relocks the target.
                    run_len = $urandom_range(1, 5);
                    for (int k = 0; k < run_len; k++) begin
                        walk_heading = walk_heading + 16'($urandom_range(0, 400)) - 16'd200;
                        t = make_tick(walk_heading, $urandom_range(0, 510) - 255,
                                      ($urandom_range(0, 1) != 0) ? $urandom_range(11, 255)
                                                                  : -$urandom_range(11, 255),
                                      pick_speed());
                        offer_tick(t, 1'b0, no_want);
                    end
                end else begin
                    // Noise: every field takes any bit pattern.
                    run_len = $urandom_range(1, 4);
                    for (int k = 0; k < run_len; k++) begin
                        t.heading  = 16'($urandom);
                        t.throttle = 9'($urandom);
                        t.steer    = 9'($urandom);
                        t.speed    = 8'($urandom);
                        offer_tick(t, 1'b0, no_want);
                    end
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (wheel_q.size() != 0) begin
            report_mismatch("results never delivered", 0, wheel_q.size());
        end

        $display("Run covered %0d ticks (%0d directed, %0d random) under %0d settings.",
                 ticks_sent, random_start, ticks_sent - random_start, settings_used);
        $display("%0d results checked, %0d mismatching fields.", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
